/* sv/lts_pkg.sv */
// shared types and constants for the line token scanner
// no dependencies; imported by lts_step and line_token_scanner_top
`default_nettype none

package lts_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_COMMENT = 2'd1,
        MODE_STRING  = 2'd2,
        MODE_ESCAPE  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        EV_TOKEN_CHAR = 3'd0,
        EV_TOKEN_END  = 3'd1,
        EV_LINE_END   = 3'd2,
        EV_ERROR      = 3'd3,
        EV_DONE       = 3'd4
    } t_event;

    typedef enum logic [2:0] {
        ERR_BAD_CHAR       = 3'd0,
        ERR_STRING_SPANS   = 3'd1,
        ERR_NON_ASCII      = 3'd2,
        ERR_BAD_ESCAPE     = 3'd3,
        ERR_INCOMPLETE_ESC = 3'd4,
        ERR_UNCLOSED       = 3'd5
    } t_err;

    typedef struct packed {
        t_mode       mode;
        logic        in_word;
        logic        after_cr;
        logic        line_has_token;
        logic        error_seen;
        logic [31:0] cur_line;
        logic [31:0] cur_column;
        logic [31:0] start_line;
        logic [31:0] start_column;
    } t_state;

    typedef struct packed {
        t_event      kind;
        logic [7:0]  char_out;
        logic        is_quoted;
        logic [31:0] at_line;
        logic [31:0] at_column;
        t_err        error_kind;
    } t_result;

    localparam int unsigned MAX_RESULTS = 4;

    typedef t_result [MAX_RESULTS-1:0] t_bundle;

    localparam t_state STATE_RESET = '{
        mode:           MODE_NORMAL,
        in_word:        1'b0,
        after_cr:       1'b0,
        line_has_token: 1'b0,
        error_seen:     1'b0,
        cur_line:       32'd1,
        cur_column:     32'd1,
        start_line:     32'd1,
        start_column:   32'd1
    };

    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_HASH       = 8'h23;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_BSLASH     = 8'h5C;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_N    = 8'h6E;
    localparam logic [7:0] CH_LOWER_R    = 8'h72;
    localparam logic [7:0] CH_LOWER_T    = 8'h74;
    localparam logic [7:0] ASCII_MAX     = 8'd127;

endpackage

`default_nettype wire

/* sv/lts_step.sv */
// per-byte scan logic: next scanner state and the list of results for one byte
// depends on lts_pkg
`default_nettype none

module lts_step import lts_pkg::*; (
    input  t_state       i_state,
    input  logic [7:0]   i_byte_value,
    input  logic         i_final_byte,
    output t_state       o_state,
    output t_bundle      o_res,
    output logic [2:0]   o_count
);

    function automatic t_result mk_res(t_event kind, logic [7:0] ch, logic quoted,
                                       logic [31:0] line, logic [31:0] col, t_err ek);
        t_result r;
        r.kind       = kind;
        r.char_out   = ch;
        r.is_quoted  = quoted;
        r.at_line    = line;
        r.at_column  = col;
        r.error_kind = ek;
        return r;
    endfunction

    function automatic logic is_word_char(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || c == CH_UNDERSCORE ||
               c == CH_MINUS || c == CH_PLUS;
    endfunction

    t_state     s;
    t_bundle    res;
    logic [2:0] cnt;
    logic [7:0] c;
    logic       is_brk;
    logic       skip;
    logic [7:0] esc_char;
    logic       esc_ok;

    // at most four results per byte, so the slot index never overflows
    always_comb begin
        s        = i_state;
        res      = '0;
        cnt      = 3'd0;
        c        = i_byte_value;
        is_brk   = (c == CH_CR) || (c == CH_LF);
        skip     = 1'b0;
        esc_char = 8'd0;
        esc_ok   = 1'b1;

        if (!s.error_seen) begin
            // lf right after cr belongs to the same break
            skip       = s.after_cr && (c == CH_LF);
            s.after_cr = 1'b0;
            if (!skip) begin
                unique case (s.mode)
                    MODE_COMMENT: begin
                        if (is_brk) begin
                            s.mode = MODE_NORMAL;
                            if (s.line_has_token) begin
                                res[cnt[1:0]] = mk_res(EV_LINE_END, 8'd0, 1'b0,
                                                       s.cur_line, s.cur_column, ERR_BAD_CHAR);
                                cnt = cnt + 3'd1;
                            end
                            s.line_has_token = 1'b0;
                            s.cur_line       = s.cur_line + 32'd1;
                            s.cur_column     = 32'd1;
                            s.after_cr       = (c == CH_CR);
                        end else begin
                            s.cur_column = s.cur_column + 32'd1;
                        end
                    end
                    MODE_STRING: begin
                        if (c == CH_QUOTE) begin
                            res[cnt[1:0]] = mk_res(EV_TOKEN_END, 8'd0, 1'b1,
                                                   s.start_line, s.start_column, ERR_BAD_CHAR);
                            cnt = cnt + 3'd1;
                            s.line_has_token = 1'b1;
                            s.mode           = MODE_NORMAL;
                            s.cur_column     = s.cur_column + 32'd1;
                        end else if (is_brk) begin
                            res[cnt[1:0]] = mk_res(EV_ERROR, 8'd0, 1'b0,
                                                   s.start_line, s.start_column,
                                                   ERR_STRING_SPANS);
                            cnt = cnt + 3'd1;
                            s.error_seen = 1'b1;
                        end else if (c > ASCII_MAX) begin
                            res[cnt[1:0]] = mk_res(EV_ERROR, 8'd0, 1'b0,
                                                   s.cur_line, s.cur_column, ERR_NON_ASCII);
                            cnt = cnt + 3'd1;
                            s.error_seen = 1'b1;
                        end else if (c == CH_BSLASH) begin
                            s.mode       = MODE_ESCAPE;
                            s.cur_column = s.cur_column + 32'd1;
                        end else begin
                            res[cnt[1:0]] = mk_res(EV_TOKEN_CHAR, c, 1'b1,
                                                   s.start_line, s.start_column, ERR_BAD_CHAR);
                            cnt = cnt + 3'd1;
                            s.cur_column = s.cur_column + 32'd1;
                        end
                    end
                    MODE_ESCAPE: begin
                        priority if (c == CH_QUOTE)   esc_char = CH_QUOTE;
                        else if (c == CH_BSLASH)      esc_char = CH_BSLASH;
                        else if (c == CH_LOWER_N)     esc_char = CH_LF;
                        else if (c == CH_LOWER_R)     esc_char = CH_CR;
                        else if (c == CH_LOWER_T)     esc_char = CH_TAB;
                        else                          esc_ok   = 1'b0;
                        if (esc_ok) begin
                            res[cnt[1:0]] = mk_res(EV_TOKEN_CHAR, esc_char, 1'b1,
                                                   s.start_line, s.start_column, ERR_BAD_CHAR);
                            cnt = cnt + 3'd1;
                            s.mode       = MODE_STRING;
                            s.cur_column = s.cur_column + 32'd1;
                        end else begin
                            res[cnt[1:0]] = mk_res(EV_ERROR, 8'd0, 1'b0,
                                                   s.cur_line, s.cur_column, ERR_BAD_ESCAPE);
                            cnt = cnt + 3'd1;
                            s.error_seen = 1'b1;
                        end
                    end
                    MODE_NORMAL: begin
                        if (is_word_char(c)) begin
                            if (!s.in_word) begin
                                s.in_word        = 1'b1;
                                s.start_line     = s.cur_line;
                                s.start_column   = s.cur_column;
                                s.line_has_token = 1'b1;
                            end
                            res[cnt[1:0]] = mk_res(EV_TOKEN_CHAR, c, 1'b0,
                                                   s.start_line, s.start_column, ERR_BAD_CHAR);
                            cnt = cnt + 3'd1;
                            s.cur_column = s.cur_column + 32'd1;
                        end else begin
                            // any other byte closes an open word first
                            if (s.in_word) begin
                                res[cnt[1:0]] = mk_res(EV_TOKEN_END, 8'd0, 1'b0,
                                                       s.start_line, s.start_column,
                                                       ERR_BAD_CHAR);
                                cnt = cnt + 3'd1;
                                s.in_word = 1'b0;
                            end
                            if (is_brk) begin
                                if (s.line_has_token) begin
                                    res[cnt[1:0]] = mk_res(EV_LINE_END, 8'd0, 1'b0,
                                                           s.cur_line, s.cur_column,
                                                           ERR_BAD_CHAR);
                                    cnt = cnt + 3'd1;
                                end
                                s.line_has_token = 1'b0;
                                s.cur_line       = s.cur_line + 32'd1;
                                s.cur_column     = 32'd1;
                                s.after_cr       = (c == CH_CR);
                            end else if (c == CH_SPACE || c == CH_TAB) begin
                                s.cur_column = s.cur_column + 32'd1;
                            end else if (c == CH_HASH) begin
                                s.mode       = MODE_COMMENT;
                                s.cur_column = s.cur_column + 32'd1;
                            end else if (c == CH_QUOTE) begin
                                s.start_line   = s.cur_line;
                                s.start_column = s.cur_column;
                                s.mode         = MODE_STRING;
                                s.cur_column   = s.cur_column + 32'd1;
                            end else begin
                                res[cnt[1:0]] = mk_res(EV_ERROR, 8'd0, 1'b0,
                                                       s.cur_line, s.cur_column,
                                                       ERR_BAD_CHAR);
                                cnt = cnt + 3'd1;
                                s.error_seen = 1'b1;
                            end
                        end
                    end
                endcase
            end
        end

        if (i_final_byte) begin
            if (!s.error_seen) begin
                if (s.mode == MODE_STRING) begin
                    res[cnt[1:0]] = mk_res(EV_ERROR, 8'd0, 1'b0,
                                           s.start_line, s.start_column, ERR_UNCLOSED);
                    cnt = cnt + 3'd1;
                end else if (s.mode == MODE_ESCAPE) begin
                    res[cnt[1:0]] = mk_res(EV_ERROR, 8'd0, 1'b0,
                                           s.start_line, s.start_column, ERR_INCOMPLETE_ESC);
                    cnt = cnt + 3'd1;
                end else begin
                    if (s.in_word) begin
                        res[cnt[1:0]] = mk_res(EV_TOKEN_END, 8'd0, 1'b0,
                                               s.start_line, s.start_column, ERR_BAD_CHAR);
                        cnt = cnt + 3'd1;
                    end
                    if (s.line_has_token) begin
                        res[cnt[1:0]] = mk_res(EV_LINE_END, 8'd0, 1'b0,
                                               s.cur_line, s.cur_column, ERR_BAD_CHAR);
                        cnt = cnt + 3'd1;
                    end
                end
            end
            res[cnt[1:0]] = mk_res(EV_DONE, 8'd0, 1'b0, 32'd0, 32'd0, ERR_BAD_CHAR);
            cnt = cnt + 3'd1;
            // next byte starts a fresh source
            s = STATE_RESET;
        end

        o_state = s;
        o_res   = res;
        o_count = cnt;
    end

endmodule

`default_nettype wire

/* sv/line_token_scanner_top.sv */
// top level of the line token scanner: input register, result bundle and output drain
// depends on lts_pkg and lts_step
`default_nettype none

// Scans source text one byte per transfer and reports token characters, token ends,
// line ends, errors and a done event, one result per output transfer. A byte is held
// in an input register, the scan logic works out all of its results (up to four)
// combinationally, and they are loaded into a four-entry result bundle that drains
// through the output port one entry a cycle unless the receiver stalls. A byte that
// gives zero or one result frees the bundle for the next byte, so the block runs at
// one byte per cycle on ordinary text without output stalls; a byte that gives more
// results holds the input until the last leaves through the single output port. The
// next byte is taken while the last result of the previous byte is being transferred.
module line_token_scanner_top import lts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_value,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_event_kind,
    output logic [7:0]  o_char_out,
    output logic        o_is_quoted,
    output logic [31:0] o_at_line,
    output logic [31:0] o_at_column,
    output logic [2:0]  o_error_kind,
    output logic        o_run_end
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_final;
    t_state      r_state;
    t_state      n_state;
    t_bundle     r_res;
    t_bundle     n_res;
    logic [2:0]  r_cnt;
    logic [2:0]  n_cnt;
    logic [1:0]  r_idx;
    logic        out_xfer;
    logic        last;
    logic        take;
    t_result     cur;

    lts_step u_step (
        .i_state      (r_state),
        .i_byte_value (r_in_byte),
        .i_final_byte (r_in_final),
        .o_state      (n_state),
        .o_res        (n_res),
        .o_count      (n_cnt)
    );

    assign o_valid  = (r_cnt != 3'd0);
    assign out_xfer = o_valid && !i_stall;
    assign last     = ({1'b0, r_idx} == (r_cnt - 3'd1));
    // bundle is free when empty or when its last entry leaves this cycle
    assign take     = r_in_valid && ((r_cnt == 3'd0) || (out_xfer && last));
    assign o_stall  = r_in_valid && !take;

    assign cur          = r_res[r_idx];
    assign o_event_kind = cur.kind;
    assign o_char_out   = cur.char_out;
    assign o_is_quoted  = cur.is_quoted;
    assign o_at_line    = cur.at_line;
    assign o_at_column  = cur.at_column;
    assign o_error_kind = cur.error_kind;
    assign o_run_end    = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte  <= i_byte_value;
            r_in_final <= i_final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
            r_cnt   <= 3'd0;
            r_idx   <= 2'd0;
        end else if (take) begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= 2'd0;
        end else if (out_xfer) begin
            if (last) begin
                r_cnt <= 3'd0;
                r_idx <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= n_res;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("result bundle count out of range");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_kind == EV_DONE) |-> o_run_end)
        else $error("done result is not the last of its byte");

    a_final_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && r_in_final |=> (r_state.mode == MODE_NORMAL) && !r_state.error_seen &&
                               (r_state.cur_line == 32'd1) && (r_state.cur_column == 32'd1))
        else $error("scanner state not reset after final byte");

    a_final_gives_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && r_in_final |=> o_valid && (r_cnt != 3'd0))
        else $error("final byte produced no results");

endmodule

`default_nettype wire

/* tb/line_token_scanner_checker.sv */
// checker for the line token scanner: watches both channels, predicts the result stream
// of every accepted byte and compares it field by field; depends on lts_pkg
module line_token_scanner_checker import lts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_byte_value,
    input  logic        i_final_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_event_kind,
    input  logic [7:0]  i_char_out,
    input  logic        i_is_quoted,
    input  logic [31:0] i_at_line,
    input  logic [31:0] i_at_column,
    input  logic [2:0]  i_error_kind,
    input  logic        i_run_end,
    output int          o_mismatches,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 60;
    // error_kind reads zero on every event that is not an error
    localparam t_err ERR_NONE = ERR_BAD_CHAR;

    typedef struct packed {
        t_result res;
        logic    run_end;
    } t_scan_event;

    t_scan_event expected_events[$];
    int          byte_results;
    int          results_seen;
    int          mismatch_count;

    // scanner state kept by the predictor
    t_mode       mode_q;
    logic        word_open;
    logic        cr_pending;
    logic        line_used;
    logic        halted;
    logic [31:0] line_no;
    logic [31:0] col_no;
    logic [31:0] tok_line;
    logic [31:0] tok_col;

    function automatic void reset_scanner();
        mode_q     = MODE_NORMAL;
        word_open  = 1'b0;
        cr_pending = 1'b0;
        line_used  = 1'b0;
        halted     = 1'b0;
        line_no    = 32'd1;
        col_no     = 32'd1;
        tok_line   = 32'd1;
        tok_col    = 32'd1;
    endfunction

    function automatic void push_event(t_event kind, logic [7:0] ch, logic quoted,
                                       logic [31:0] ln, logic [31:0] cl, t_err ek);
        t_scan_event ev;
        ev.res.kind       = kind;
        ev.res.char_out   = ch;
        ev.res.is_quoted  = quoted;
        ev.res.at_line    = ln;
        ev.res.at_column  = cl;
        ev.res.error_kind = ek;
        ev.run_end        = 1'b0;
        expected_events.insert(expected_events.size(), ev);
        byte_results++;
    endfunction

    function automatic void raise_error(t_err ek, logic [31:0] ln, logic [31:0] cl);
        push_event(EV_ERROR, 8'h00, 1'b0, ln, cl, ek);
        halted = 1'b1;
    endfunction

    function automatic void close_word();
        if (word_open) begin
            push_event(EV_TOKEN_END, 8'h00, 1'b0, tok_line, tok_col, ERR_NONE);
            word_open = 1'b0;
        end
    endfunction

    function automatic void break_line(logic [7:0] c);
        if (line_used) push_event(EV_LINE_END, 8'h00, 1'b0, line_no, col_no, ERR_NONE);
        line_used  = 1'b0;
        line_no    = line_no + 32'd1;
        col_no     = 32'd1;
        cr_pending = (c == CH_CR);
    endfunction

    function automatic logic is_word_char(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9")
            || c == CH_UNDERSCORE || c == CH_MINUS || c == CH_PLUS;
    endfunction

    // works out every event one source byte causes and queues them in order
    function automatic void scan_source_byte(logic [7:0] c, logic fin);
        logic        skip;
        logic        esc_ok;
        logic [7:0]  dec;
        byte_results = 0;
        if (!halted) begin
            // LF right after CR belongs to the same break
            skip       = cr_pending && c == CH_LF;
            cr_pending = 1'b0;
            if (!skip) begin
                case (mode_q)
                    MODE_COMMENT: begin
                        if (c == CH_CR || c == CH_LF) begin
                            mode_q = MODE_NORMAL;
                            break_line(c);
                        end else begin
                            col_no = col_no + 32'd1;
                        end
                    end
                    MODE_STRING: begin
                        if (c == CH_QUOTE) begin
                            push_event(EV_TOKEN_END, 8'h00, 1'b1, tok_line, tok_col, ERR_NONE);
                            line_used = 1'b1;
                            mode_q    = MODE_NORMAL;
                            col_no    = col_no + 32'd1;
                        end else if (c == CH_CR || c == CH_LF) begin
                            raise_error(ERR_STRING_SPANS, tok_line, tok_col);
                        end else if (c > ASCII_MAX) begin
                            raise_error(ERR_NON_ASCII, line_no, col_no);
                        end else if (c == CH_BSLASH) begin
                            mode_q = MODE_ESCAPE;
                            col_no = col_no + 32'd1;
                        end else begin
                            push_event(EV_TOKEN_CHAR, c, 1'b1, tok_line, tok_col, ERR_NONE);
                            col_no = col_no + 32'd1;
                        end
                    end
                    MODE_ESCAPE: begin
                        esc_ok = 1'b1;
                        dec    = 8'h00;
                        case (c)
                            CH_QUOTE:   dec = CH_QUOTE;
                            CH_BSLASH:  dec = CH_BSLASH;
                            CH_LOWER_N: dec = CH_LF;
                            CH_LOWER_R: dec = CH_CR;
                            CH_LOWER_T: dec = CH_TAB;
                            default:    esc_ok = 1'b0;
                        endcase
                        if (!esc_ok) begin
                            raise_error(ERR_BAD_ESCAPE, line_no, col_no);
                        end else begin
                            push_event(EV_TOKEN_CHAR, dec, 1'b1, tok_line, tok_col, ERR_NONE);
                            mode_q = MODE_STRING;
                            col_no = col_no + 32'd1;
                        end
                    end
                    default: begin
                        if (c == CH_CR || c == CH_LF) begin
                            close_word();
                            break_line(c);
                        end else if (c == CH_SPACE || c == CH_TAB) begin
                            close_word();
                            col_no = col_no + 32'd1;
                        end else if (c == CH_HASH) begin
                            close_word();
                            mode_q = MODE_COMMENT;
                            col_no = col_no + 32'd1;
                        end else if (c == CH_QUOTE) begin
                            close_word();
                            tok_line = line_no;
                            tok_col  = col_no;
                            mode_q   = MODE_STRING;
                            col_no   = col_no + 32'd1;
                        end else if (is_word_char(c)) begin
                            if (!word_open) begin
                                word_open = 1'b1;
                                tok_line  = line_no;
                                tok_col   = col_no;
                                line_used = 1'b1;
                            end
                            push_event(EV_TOKEN_CHAR, c, 1'b0, tok_line, tok_col, ERR_NONE);
                            col_no = col_no + 32'd1;
                        end else begin
                            close_word();
                            raise_error(ERR_BAD_CHAR, line_no, col_no);
                        end
                    end
                endcase
            end
        end
        if (fin) begin
            if (!halted) begin
                if (mode_q == MODE_STRING) begin
                    raise_error(ERR_UNCLOSED, tok_line, tok_col);
                end else if (mode_q == MODE_ESCAPE) begin
                    raise_error(ERR_INCOMPLETE_ESC, tok_line, tok_col);
                end else begin
                    close_word();
                    if (line_used)
                        push_event(EV_LINE_END, 8'h00, 1'b0, line_no, col_no, ERR_NONE);
                end
            end
            push_event(EV_DONE, 8'h00, 1'b0, 32'd0, 32'd0, ERR_NONE);
            reset_scanner();
        end
        if (byte_results > 0) begin
            expected_events[expected_events.size() - 1].run_end = 1'b1;
        end
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      results_seen, name, got, want));
    endtask

    always @(posedge i_clk) begin
        t_scan_event want;
        if (!i_rst_n) begin
            reset_scanner();
            expected_events.delete();
        end else begin
            if (i_in_valid && !i_in_stall) scan_source_byte(i_byte_value, i_final_byte);
            if (i_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_events.size() == 0) begin
                    report_mismatch($sformatf("result %0d of kind %0d with nothing expected",
                                              results_seen, i_event_kind));
                end else begin
                    want = expected_events.pop_front();
                    check_field("event_kind", 32'(i_event_kind), 32'(want.res.kind));
                    check_field("char_out", 32'(i_char_out), 32'(want.res.char_out));
                    check_field("is_quoted", 32'(i_is_quoted), 32'(want.res.is_quoted));
                    check_field("at_line", i_at_line, want.res.at_line);
                    check_field("at_column", i_at_column, want.res.at_column);
                    check_field("error_kind", 32'(i_error_kind), 32'(want.res.error_kind));
                    check_field("run_end", 32'(i_run_end), 32'(want.run_end));
                end
            end
        end
        o_pending    <= expected_events.size();
        o_mismatches <= mismatch_count;
    end

endmodule

/* tb/line_token_scanner_top_tb.sv */
// testbench top for the line token scanner: clock, reset, source text stimulus and verdict
// depends on lts_pkg, line_token_scanner_top and line_token_scanner_checker
module line_token_scanner_top_tb import lts_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 9;
    localparam int RANDOM_ITEMS   = 75;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 8;
    // well above the receiver hold plus the up to four results of one byte
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_src_byte;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [7:0]  i_byte_value = 8'h00;
    logic        i_final_byte = 1'b0;
    logic        i_stall      = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [2:0]  o_event_kind;
    logic [7:0]  o_char_out;
    logic        o_is_quoted;
    logic [31:0] o_at_line;
    logic [31:0] o_at_column;
    logic [2:0]  o_error_kind;
    logic        o_run_end;
    int          mismatches;
    int          pending;

    t_src_byte src_q[$];
    logic      no_idle  = 1'b0;
    logic      hold_req = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    line_token_scanner_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_byte_value (i_byte_value),
        .i_final_byte (i_final_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_event_kind (o_event_kind),
        .o_char_out   (o_char_out),
        .o_is_quoted  (o_is_quoted),
        .o_at_line    (o_at_line),
        .o_at_column  (o_at_column),
        .o_error_kind (o_error_kind),
        .o_run_end    (o_run_end)
    );

    line_token_scanner_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_byte_value (i_byte_value),
        .i_final_byte (i_final_byte),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_event_kind (o_event_kind),
        .i_char_out   (o_char_out),
        .i_is_quoted  (o_is_quoted),
        .i_at_line    (o_at_line),
        .i_at_column  (o_at_column),
        .i_error_kind (o_error_kind),
        .i_run_end    (o_run_end),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    function automatic void add_byte(logic [7:0] v, logic last);
        t_src_byte b;
        b.value = v;
        b.last  = last;
        src_q.insert(src_q.size(), b);
    endfunction

    function automatic logic [7:0] pick_word_char();
        case ($urandom_range(3))
            0:       return "a" + 8'($urandom_range(25));
            1:       return "A" + 8'($urandom_range(25));
            2:       return "0" + 8'($urandom_range(9));
            default: begin
                case ($urandom_range(2))
                    0:       return CH_UNDERSCORE;
                    1:       return CH_MINUS;
                    default: return CH_PLUS;
                endcase
            end
        endcase
    endfunction

    function automatic logic [7:0] pick_escape();
        if ($urandom_range(4) == 0) return 8'($urandom_range(255));
        case ($urandom_range(4))
            0:       return CH_QUOTE;
            1:       return CH_BSLASH;
            2:       return CH_LOWER_N;
            3:       return CH_LOWER_R;
            default: return CH_LOWER_T;
        endcase
    endfunction

    // one source: mostly well-formed words, blanks, strings, comments and breaks,
    // with the odd stray byte or unclosed string
    function automatic void add_random_source();
        int         n_seg;
        int         r;
        int         len;
        logic [7:0] v;
        n_seg = $urandom_range(1, 6);
        for (int s = 0; s < n_seg; s++) begin
            r = $urandom_range(99);
            if (r < 30) begin
                len = $urandom_range(1, 6);
                repeat (len) add_byte(pick_word_char(), 1'b0);
            end else if (r < 45) begin
                add_byte($urandom_range(1) ? CH_SPACE : CH_TAB, 1'b0);
            end else if (r < 65) begin
                add_byte(CH_QUOTE, 1'b0);
                len = $urandom_range(0, 5);
                repeat (len) begin
                    if ($urandom_range(3) == 0) begin
                        add_byte(CH_BSLASH, 1'b0);
                        add_byte(pick_escape(), 1'b0);
                    end else begin
                        do v = 8'($urandom_range(8'h20, 8'h7E));
                        while (v == CH_QUOTE || v == CH_BSLASH);
                        add_byte(v, 1'b0);
                    end
                end
                if ($urandom_range(9) != 0) add_byte(CH_QUOTE, 1'b0);
            end else if (r < 75) begin
                add_byte(CH_HASH, 1'b0);
                len = $urandom_range(0, 4);
                repeat (len) begin
                    do v = 8'($urandom_range(255));
                    while (v == CH_CR || v == CH_LF);
                    add_byte(v, 1'b0);
                end
            end else if (r < 92) begin
                case ($urandom_range(2))
                    0:       add_byte(CH_CR, 1'b0);
                    1:       add_byte(CH_LF, 1'b0);
                    default: begin
                        add_byte(CH_CR, 1'b0);
                        add_byte(CH_LF, 1'b0);
                    end
                endcase
            end else begin
                add_byte(8'($urandom_range(255)), 1'b0);
            end
        end
        src_q[src_q.size() - 1].last = 1'b1;
    endfunction

    task automatic send_byte(t_src_byte b);
        while (!no_idle && $urandom_range(99) < 25) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_byte_value <= b.value;
        i_final_byte <= b.last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // receiver: random stalls, one long hold-off so the block backs up into its input
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_stall <= !no_idle && $urandom_range(99) < 25;
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet = 0;
            else quiet++;
        end
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int first_random;

        // word, line end on LF, bad char after a word, bytes ignored after the error
        add_byte("z", 1'b0);
        add_byte(CH_LF, 1'b0);
        add_byte("a", 1'b0);
        add_byte("!", 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b1);
        // comment with a high byte, CR LF as one break, string with an escape, close on final
        add_byte(CH_HASH, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(CH_CR, 1'b0);
        add_byte(CH_LF, 1'b0);
        add_byte(CH_SPACE, 1'b0);
        add_byte(CH_QUOTE, 1'b0);
        add_byte(CH_BSLASH, 1'b0);
        add_byte(CH_LOWER_N, 1'b0);
        add_byte(CH_QUOTE, 1'b1);
        // source ends right after a backslash
        add_byte(CH_QUOTE, 1'b0);
        add_byte(CH_BSLASH, 1'b1);
        // string broken by a line break
        add_byte(CH_QUOTE, 1'b0);
        add_byte("x", 1'b0);
        add_byte(CH_LF, 1'b1);
        // non-ascii inside a string
        add_byte(CH_QUOTE, 1'b0);
        add_byte(8'h80, 1'b1);
        // high byte after a backslash
        add_byte(CH_QUOTE, 1'b0);
        add_byte(CH_BSLASH, 1'b0);
        add_byte(8'hC0, 1'b1);
        // string left open at the end
        add_byte(CH_QUOTE, 1'b0);
        add_byte("Z", 1'b1);
        // one-char word as the whole source: four results from one byte
        add_byte("Q", 1'b1);

        first_random = src_q.size();
        while (src_q.size() - first_random < RANDOM_ITEMS) add_random_source();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < src_q.size(); i++) begin
            if (i == first_random) hold_req = 1'b1;
            no_idle = (i >= first_random + 40 && i < first_random + 80);
            send_byte(src_q[i]);
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* line_token_scanner_top.f */
sv/lts_pkg.sv
sv/lts_step.sv
sv/line_token_scanner_top.sv
tb/line_token_scanner_checker.sv
tb/line_token_scanner_top_tb.sv
